// ===== rtl/lpvg_pkg.sv =====
// ----------------------------------------------------------------------------
// lpvg_pkg: shared types and constants of the lidar point validity gate
// Reason codes, register map, configuration bundle and queue sizing.
// ----------------------------------------------------------------------------
package lpvg_pkg;

    localparam int RANGE_W     = 23;
    localparam int INTENSITY_W = 16;
    localparam int TIME_W      = 32;
    localparam int FACTOR_W    = 16;
    localparam int INDEX_W     = 20;
    localparam int KEPT_W      = 21;
    localparam int REASON_W    = 3;

    localparam int INDEX_HW_MAX = 1048575;
    localparam int KEPT_HW_MAX  = 2097151;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_GATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION     = 3'd5;

    localparam logic [RANGE_W-1:0]     MIN_RANGE_RST      = 23'd0;
    localparam logic [RANGE_W-1:0]     MAX_RANGE_RST      = 23'h7FFFFF;
    localparam logic [INTENSITY_W-1:0] INTENSITY_LOW_RST  = 16'h0000;
    localparam logic [INTENSITY_W-1:0] INTENSITY_HIGH_RST = 16'hFFFF;
    localparam logic [FACTOR_W-1:0]    DECIMATION_RST     = 16'd1;

    typedef enum logic [REASON_W-1:0] {
        REASON_KEPT      = 3'd0,
        REASON_NONFINITE = 3'd1,
        REASON_TOO_NEAR  = 3'd2,
        REASON_TOO_FAR   = 3'd3,
        REASON_INTENSITY = 3'd4,
        REASON_DECIMATED = 3'd5
    } reason_t;

    typedef struct packed {
        logic    first_of_scan;
        reason_t reason;
    } gate_info_t;

    typedef struct packed {
        logic [RANGE_W-1:0]     min_range_mm;
        logic [RANGE_W-1:0]     max_range_mm;
        logic                   intensity_gate_on;
        logic [INTENSITY_W-1:0] intensity_low;
        logic [INTENSITY_W-1:0] intensity_high;
    } gate_cfg_t;

endpackage

// ===== rtl/lpvg_front.sv =====
// ----------------------------------------------------------------------------
// lpvg_front: point intake and gate classification
// Squares the coordinates, sums them over two stages and classifies each
// point against the non-finite, range and intensity gates.
// ----------------------------------------------------------------------------
module lpvg_front #(
    parameter int COORD_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  first_of_scan,
    input  logic                                  non_finite,
    input  logic signed [COORD_BITS-1:0]          x_mm,
    input  logic signed [COORD_BITS-1:0]          y_mm,
    input  logic signed [COORD_BITS-1:0]          z_mm,
    input  logic [lpvg_pkg::INTENSITY_W-1:0]      intensity,
    input  logic signed [lpvg_pkg::TIME_W-1:0]    time_offset_ns,
    input  lpvg_pkg::gate_cfg_t                   cfg,
    input  logic [lpvg_pkg::QUEUE_CNT_W-1:0]      queue_count,
    output logic                                  push,
    output lpvg_pkg::gate_info_t                  push_info,
    output logic [3*COORD_BITS+lpvg_pkg::INTENSITY_W+lpvg_pkg::TIME_W-1:0] push_payload
);
    import lpvg_pkg::*;

    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int SUM_W      = SQ_W + 1;
    localparam int RANGE_SQ_W = 2 * RANGE_W;
    localparam int CMP_W      = (SQ_W + 2 > RANGE_SQ_W) ? SQ_W + 2 : RANGE_SQ_W;
    localparam int PAY_W      = 3 * COORD_BITS + INTENSITY_W + TIME_W;
    localparam int OCC_W      = QUEUE_CNT_W + 1;

    localparam logic [RANGE_SQ_W-1:0] MIN_SQ_RST =
        RANGE_SQ_W'(MIN_RANGE_RST) * RANGE_SQ_W'(MIN_RANGE_RST);
    localparam logic [RANGE_SQ_W-1:0] MAX_SQ_RST =
        RANGE_SQ_W'(MAX_RANGE_RST) * RANGE_SQ_W'(MAX_RANGE_RST);

    logic                  accept;
    logic [OCC_W-1:0]      occupancy;
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    logic [COORD_BITS-1:0] mag_z;
    logic                  int_fail;
    logic [CMP_W-1:0]      range_sq;

    logic                  s1_valid_reg;
    logic                  s1_first_reg;
    logic                  s1_nonfin_reg;
    logic                  s1_int_fail_reg;
    logic [SQ_W-1:0]       s1_sq_x_reg;
    logic [SQ_W-1:0]       s1_sq_y_reg;
    logic [SQ_W-1:0]       s1_sq_z_reg;
    logic [PAY_W-1:0]      s1_payload_reg;

    logic                  s2_valid_reg;
    logic                  s2_first_reg;
    logic                  s2_nonfin_reg;
    logic                  s2_int_fail_reg;
    logic [SUM_W-1:0]      s2_sum_xy_reg;
    logic [SQ_W-1:0]       s2_sq_z_reg;
    logic [PAY_W-1:0]      s2_payload_reg;

    logic [RANGE_SQ_W-1:0] min_sq_reg;
    logic [RANGE_SQ_W-1:0] max_sq_reg;

    assign occupancy = OCC_W'(queue_count) + OCC_W'(s1_valid_reg) + OCC_W'(s2_valid_reg);
    assign in_ready  = occupancy < OCC_W'(QUEUE_DEPTH);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        mag_x = x_mm[COORD_BITS-1] ? (~x_mm + 1'b1) : x_mm;
        mag_y = y_mm[COORD_BITS-1] ? (~y_mm + 1'b1) : y_mm;
        mag_z = z_mm[COORD_BITS-1] ? (~z_mm + 1'b1) : z_mm;
        int_fail = cfg.intensity_gate_on &&
                   ((intensity < cfg.intensity_low) || (intensity > cfg.intensity_high));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            min_sq_reg   <= MIN_SQ_RST;
            max_sq_reg   <= MAX_SQ_RST;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            min_sq_reg   <= RANGE_SQ_W'(cfg.min_range_mm) * RANGE_SQ_W'(cfg.min_range_mm);
            max_sq_reg   <= RANGE_SQ_W'(cfg.max_range_mm) * RANGE_SQ_W'(cfg.max_range_mm);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg    <= first_of_scan;
        s1_nonfin_reg   <= non_finite;
        s1_int_fail_reg <= int_fail;
        s1_sq_x_reg     <= SQ_W'(mag_x) * SQ_W'(mag_x);
        s1_sq_y_reg     <= SQ_W'(mag_y) * SQ_W'(mag_y);
        s1_sq_z_reg     <= SQ_W'(mag_z) * SQ_W'(mag_z);
        s1_payload_reg  <= {time_offset_ns, intensity, z_mm, y_mm, x_mm};

        s2_first_reg    <= s1_first_reg;
        s2_nonfin_reg   <= s1_nonfin_reg;
        s2_int_fail_reg <= s1_int_fail_reg;
        s2_sum_xy_reg   <= SUM_W'(s1_sq_x_reg) + SUM_W'(s1_sq_y_reg);
        s2_sq_z_reg     <= s1_sq_z_reg;
        s2_payload_reg  <= s1_payload_reg;
    end

    assign range_sq = CMP_W'(s2_sum_xy_reg) + CMP_W'(s2_sq_z_reg);

    always_comb
    begin
        push_info.first_of_scan = s2_first_reg;
        if (s2_nonfin_reg)
        begin
            push_info.reason = REASON_NONFINITE;
        end
        else if (range_sq < CMP_W'(min_sq_reg))
        begin
            push_info.reason = REASON_TOO_NEAR;
        end
        else if (range_sq > CMP_W'(max_sq_reg))
        begin
            push_info.reason = REASON_TOO_FAR;
        end
        else if (s2_int_fail_reg)
        begin
            push_info.reason = REASON_INTENSITY;
        end
        else
        begin
            push_info.reason = REASON_KEPT;
        end
    end

    assign push         = s2_valid_reg;
    assign push_payload = s2_payload_reg;

endmodule

// ===== rtl/lpvg_queue.sv =====
// ----------------------------------------------------------------------------
// lpvg_queue: short first-in first-out queue between front and back
// Holds classified points so that the intake and the output stall apart.
// ----------------------------------------------------------------------------
module lpvg_queue #(
    parameter int WIDTH = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [WIDTH-1:0]                 push_data,
    input  logic                             pop,
    output logic [WIDTH-1:0]                 pop_data,
    output logic                             not_empty,
    output logic [lpvg_pkg::QUEUE_CNT_W-1:0] count
);
    import lpvg_pkg::*;

    logic [WIDTH-1:0]       entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = entry_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

endmodule

// ===== rtl/lpvg_back.sv =====
// ----------------------------------------------------------------------------
// lpvg_back: scan bookkeeping, decimation and output register
// Tracks the index, decimation phase and kept count of the scan and holds
// one finished word for the output side.
// ----------------------------------------------------------------------------
module lpvg_back #(
    parameter int COORD_BITS      = 24,
    parameter int SCAN_POINTS_MAX = 1048576
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  head_valid,
    input  lpvg_pkg::gate_info_t                  head_info,
    input  logic [3*COORD_BITS+lpvg_pkg::INTENSITY_W+lpvg_pkg::TIME_W-1:0] head_payload,
    output logic                                  pop,
    input  logic [lpvg_pkg::FACTOR_W-1:0]         decimation_factor,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata: scan_index, out_x_mm, out_y_mm, out_z_mm, out_intensity,
    //          out_time_offset_ns, kept_count, zero fill
    output logic [((3*COORD_BITS+89+7)/8)*8-1:0]  m_tdata,
    // m_tuser: keep, reason
    output logic [3:0]                            m_tuser
);
    import lpvg_pkg::*;

    localparam int PAY_W     = 3 * COORD_BITS + INTENSITY_W + TIME_W;
    localparam int OUT_W     = ((3 * COORD_BITS + 89 + 7) / 8) * 8;
    localparam int INDEX_LIMIT_INT =
        (SCAN_POINTS_MAX - 1 > INDEX_HW_MAX) ? INDEX_HW_MAX : SCAN_POINTS_MAX - 1;
    localparam int KEPT_LIMIT_INT =
        (SCAN_POINTS_MAX > KEPT_HW_MAX) ? KEPT_HW_MAX : SCAN_POINTS_MAX;
    localparam logic [INDEX_W-1:0] INDEX_LIMIT = INDEX_W'(INDEX_LIMIT_INT);
    localparam logic [KEPT_W-1:0]  KEPT_LIMIT  = KEPT_W'(KEPT_LIMIT_INT);

    logic [FACTOR_W-1:0] phase_reg;
    logic [FACTOR_W-1:0] phase_next;
    logic [INDEX_W-1:0]  index_reg;
    logic [INDEX_W-1:0]  index_next;
    logic [KEPT_W-1:0]   kept_reg;
    logic [KEPT_W-1:0]   kept_next;

    logic [FACTOR_W-1:0] phase_base;
    logic [INDEX_W-1:0]  index_base;
    logic [KEPT_W-1:0]   kept_base;
    logic [FACTOR_W-1:0] factor_eff;
    logic [FACTOR_W:0]   phase_inc;
    reason_t             reason_next;
    logic                keep_next;

    logic                out_valid_reg;
    logic                out_keep_reg;
    reason_t             out_reason_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [PAY_W-1:0]    out_payload_reg;
    logic [KEPT_W-1:0]   out_kept_reg;

    assign pop = head_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        phase_base  = head_info.first_of_scan ? '0 : phase_reg;
        index_base  = head_info.first_of_scan ? '0 : index_reg;
        kept_base   = head_info.first_of_scan ? '0 : kept_reg;
        factor_eff  = (decimation_factor == '0) ? FACTOR_W'(1) : decimation_factor;
        phase_inc   = {1'b0, phase_base} + 1'b1;
        index_next  = (index_base < INDEX_LIMIT) ? index_base + 1'b1 : index_base;
        phase_next  = phase_base;
        kept_next   = kept_base;
        keep_next   = 1'b0;
        reason_next = head_info.reason;
        if (head_info.reason == REASON_KEPT)
        begin
            if (phase_inc >= {1'b0, factor_eff})
            begin
                phase_next = '0;
                keep_next  = 1'b1;
                kept_next  = (kept_base < KEPT_LIMIT) ? kept_base + 1'b1 : kept_base;
            end
            else
            begin
                phase_next  = phase_inc[FACTOR_W-1:0];
                reason_next = REASON_DECIMATED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            index_reg     <= '0;
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg     <= phase_next;
                index_reg     <= index_next;
                kept_reg      <= kept_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_keep_reg    <= keep_next;
            out_reason_reg  <= reason_next;
            out_index_reg   <= index_base;
            out_payload_reg <= head_payload;
            out_kept_reg    <= kept_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_kept_reg, out_payload_reg, out_index_reg});
    assign m_tuser  = {out_reason_reg, out_keep_reg};

endmodule

// ===== rtl/lidar_point_validity_gate_top.sv =====
// ----------------------------------------------------------------------------
// lidar_point_validity_gate_top: lidar point range, intensity and decimation gate
// Classifies each point, thins the survivors of a scan and reports a keep
// flag, a reason, the index in the scan and the running kept count.
// ----------------------------------------------------------------------------
//  Port group   Direction  Carries
//  s_*          in         one point a word: tuser flags, tdata coordinates
//  m_*          out        one result a word: tuser verdict, tdata point and counts
//  p*           in/out     register writes and reads, no wait states
//
// An accepted point passes s1, s2, the queue and the output register to m_tvalid.
// The front pipeline is two stages deep and a four-entry queue feeds the back.
// One point enters a cycle unless the queue and front stages together hold four.
// Reset clears scan counters, valid flags and queue and presets config registers.
// ----------------------------------------------------------------------------
module lidar_point_validity_gate_top #(
    parameter int COORD_BITS      = 24,
    parameter int SCAN_POINTS_MAX = 1048576
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata: x_mm, y_mm, z_mm, intensity, time_offset_ns, zero fill
    input  logic [((3*COORD_BITS+48+7)/8)*8-1:0]  s_tdata,
    // s_tuser: first_of_scan, non_finite
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata: scan_index, out_x_mm, out_y_mm, out_z_mm, out_intensity,
    //          out_time_offset_ns, kept_count, zero fill
    output logic [((3*COORD_BITS+89+7)/8)*8-1:0]  m_tdata,
    // m_tuser: keep, reason
    output logic [3:0]                            m_tuser,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lpvg_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [lpvg_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [lpvg_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import lpvg_pkg::*;

    localparam int PAY_W  = 3 * COORD_BITS + INTENSITY_W + TIME_W;
    localparam int INFO_W = $bits(gate_info_t);
    localparam int Q_W    = INFO_W + PAY_W;

    logic [RANGE_W-1:0]     min_range_reg;
    logic [RANGE_W-1:0]     max_range_reg;
    logic                   gate_on_reg;
    logic [INTENSITY_W-1:0] int_low_reg;
    logic [INTENSITY_W-1:0] int_high_reg;
    logic [FACTOR_W-1:0]    factor_reg;

    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    gate_cfg_t              gate_cfg;

    logic                   push;
    gate_info_t             push_info;
    logic [PAY_W-1:0]       push_payload;
    logic                   pop;
    logic [Q_W-1:0]         head_data;
    gate_info_t             head_info;
    logic                   head_valid;
    logic [QUEUE_CNT_W-1:0] queue_count;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[CFG_IDX_W+1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg <= MIN_RANGE_RST;
            max_range_reg <= MAX_RANGE_RST;
            gate_on_reg   <= 1'b0;
            int_low_reg   <= INTENSITY_LOW_RST;
            int_high_reg  <= INTENSITY_HIGH_RST;
            factor_reg    <= DECIMATION_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MIN_RANGE:      min_range_reg <= pwdata[RANGE_W-1:0];
                REG_MAX_RANGE:      max_range_reg <= pwdata[RANGE_W-1:0];
                REG_INTENSITY_GATE: gate_on_reg   <= pwdata[0];
                REG_INTENSITY_LOW:  int_low_reg   <= pwdata[INTENSITY_W-1:0];
                REG_INTENSITY_HIGH: int_high_reg  <= pwdata[INTENSITY_W-1:0];
                REG_DECIMATION:     factor_reg    <= pwdata[FACTOR_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_MIN_RANGE:      prdata = CFG_DATA_W'(min_range_reg);
            REG_MAX_RANGE:      prdata = CFG_DATA_W'(max_range_reg);
            REG_INTENSITY_GATE: prdata = CFG_DATA_W'(gate_on_reg);
            REG_INTENSITY_LOW:  prdata = CFG_DATA_W'(int_low_reg);
            REG_INTENSITY_HIGH: prdata = CFG_DATA_W'(int_high_reg);
            REG_DECIMATION:     prdata = CFG_DATA_W'(factor_reg);
            default:            prdata = '0;
        endcase
    end

    always_comb
    begin
        gate_cfg.min_range_mm      = min_range_reg;
        gate_cfg.max_range_mm      = max_range_reg;
        gate_cfg.intensity_gate_on = gate_on_reg;
        gate_cfg.intensity_low     = int_low_reg;
        gate_cfg.intensity_high    = int_high_reg;
    end

    lpvg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .first_of_scan  (s_tuser[0]),
        .non_finite     (s_tuser[1]),
        .x_mm           (s_tdata[COORD_BITS-1:0]),
        .y_mm           (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .z_mm           (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .intensity      (s_tdata[3*COORD_BITS+INTENSITY_W-1:3*COORD_BITS]),
        .time_offset_ns (s_tdata[PAY_W-1:3*COORD_BITS+INTENSITY_W]),
        .cfg            (gate_cfg),
        .queue_count    (queue_count),
        .push           (push),
        .push_info      (push_info),
        .push_payload   (push_payload)
    );

    lpvg_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_info, push_payload}),
        .pop       (pop),
        .pop_data  (head_data),
        .not_empty (head_valid),
        .count     (queue_count)
    );

    assign head_info = gate_info_t'(head_data[Q_W-1:PAY_W]);

    lpvg_back #(
        .COORD_BITS      (COORD_BITS),
        .SCAN_POINTS_MAX (SCAN_POINTS_MAX)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head_valid        (head_valid),
        .head_info         (head_info),
        .head_payload      (head_data[PAY_W-1:0]),
        .pop               (pop),
        .decimation_factor (factor_reg),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser)
    );

endmodule

// ===== rtl/lpvg_checker.sv =====
// ----------------------------------------------------------------------------
// lpvg_checker: port-level checks of the lidar point validity gate
// Watches the stream ports for verdict consistency and word accounting.
// ----------------------------------------------------------------------------
module lpvg_checker #(
    parameter int COORD_BITS = 24
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((3*COORD_BITS+89+7)/8)*8-1:0] m_tdata,
    input logic [3:0]                           m_tuser
);
    import lpvg_pkg::*;

    localparam int MAX_OUTSTANDING = QUEUE_DEPTH + 1;

    logic       in_take;
    logic       out_take;
    logic [3:0] outstanding_reg;

    assign in_take  = s_tvalid && s_tready;
    assign out_take = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 4'(in_take) - 4'(out_take);
        end
    end

    // A stalled result word holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] == (m_tuser[3:1] == REASON_KEPT)))
        else $error("keep flag disagrees with reason");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[3:1] <= REASON_DECIMATED))
        else $error("reason code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> outstanding_reg != '0)
        else $error("result word without a matching point");

    assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 4'(MAX_OUTSTANDING))
        else $error("more points in flight than the block can hold");

endmodule

bind lidar_point_validity_gate_top lpvg_checker #(
    .COORD_BITS (COORD_BITS)
) u_lpvg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
